FILE: design/rlga_pkg.sv
// Shared widths, coefficients, codes, beat type and clamp functions of the luma converter.
package rlga_pkg;

    localparam int COEF_FRAC_BITS = 14;

    // The forward coefficients are all below one, so they fit in unsigned fraction bits.
    localparam int FCOEF_W = COEF_FRAC_BITS;
    // The inverse coefficients are below four; one more bit carries the sign.
    localparam int ICOEF_W = COEF_FRAC_BITS + 3;
    // Forward products of an 8-bit channel by a coefficient below one.
    localparam int FPROD_W = COEF_FRAC_BITS + 8;
    // Y, U, V and the offset luma, signed, with COEF_FRAC_BITS fraction bits.
    localparam int YUV_W = COEF_FRAC_BITS + 10;
    // Inverse products and sums, signed, with twice the fraction bits.
    localparam int SUM_W = ICOEF_W + YUV_W;

    localparam int OFFSET_W = 13;
    localparam int OFFSET_FRAC_BITS = 4;
    localparam int CFG_DATA_W = OFFSET_W;

    localparam logic REG_MODE_SELECT = 1'b0;
    localparam logic REG_LUMA_OFFSET = 1'b1;

    localparam logic MODE_GRAY = 1'b0;
    localparam logic MODE_ADJUST = 1'b1;

    // Round a coefficient given in thousandths to fixed point.
    function automatic longint coef_fix(input longint milli);
        return ((milli << COEF_FRAC_BITS) + 500) / 1000;
    endfunction

    localparam logic [FCOEF_W-1:0] FC_Y_R = FCOEF_W'(coef_fix(299));
    localparam logic [FCOEF_W-1:0] FC_Y_G = FCOEF_W'(coef_fix(587));
    localparam logic [FCOEF_W-1:0] FC_Y_B = FCOEF_W'(coef_fix(114));
    localparam logic [FCOEF_W-1:0] FC_U_R = FCOEF_W'(coef_fix(147));
    localparam logic [FCOEF_W-1:0] FC_U_G = FCOEF_W'(coef_fix(289));
    localparam logic [FCOEF_W-1:0] FC_U_B = FCOEF_W'(coef_fix(436));
    localparam logic [FCOEF_W-1:0] FC_V_R = FCOEF_W'(coef_fix(615));
    localparam logic [FCOEF_W-1:0] FC_V_G = FCOEF_W'(coef_fix(515));
    localparam logic [FCOEF_W-1:0] FC_V_B = FCOEF_W'(coef_fix(100));

    localparam logic signed [ICOEF_W-1:0] IC_R_V = ICOEF_W'(coef_fix(1139));
    localparam logic signed [ICOEF_W-1:0] IC_G_U = ICOEF_W'(coef_fix(395));
    localparam logic signed [ICOEF_W-1:0] IC_G_V = ICOEF_W'(coef_fix(581));
    localparam logic signed [ICOEF_W-1:0] IC_B_U = ICOEF_W'(coef_fix(2032));

    typedef struct packed {
        logic [7:0]              gray;
        logic signed [YUV_W-1:0] luma;
        logic signed [YUV_W-1:0] chroma_u;
        logic signed [YUV_W-1:0] chroma_v;
    } yuv_beat_t;

    // Clamp a value with COEF_FRAC_BITS fraction bits to 0..255 and truncate it.
    function automatic logic [7:0] clamp_yuv(input logic signed [YUV_W-1:0] x);
        logic [7:0] q;
        if (x[YUV_W-1])
        begin
            q = 8'd0;
        end
        else if (|x[YUV_W-2:COEF_FRAC_BITS+8])
        begin
            q = 8'hFF;
        end
        else
        begin
            q = x[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
        end
        return q;
    endfunction

    // Clamp a value with twice the fraction bits to 0..255 and truncate it.
    function automatic logic [7:0] clamp_sum(input logic signed [SUM_W-1:0] x);
        logic [7:0] q;
        if (x[SUM_W-1])
        begin
            q = 8'd0;
        end
        else if (|x[SUM_W-2:2*COEF_FRAC_BITS+8])
        begin
            q = 8'hFF;
        end
        else
        begin
            q = x[2*COEF_FRAC_BITS+7:2*COEF_FRAC_BITS];
        end
        return q;
    endfunction

endpackage

FILE: design/rlga_fwd.sv
// Forward conversion: products in stage one; Y/U/V sums, gray clamp and luma offset in stage two.
module rlga_fwd (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        red,
    input  logic [7:0]                        green,
    input  logic [7:0]                        blue,
    input  logic signed [rlga_pkg::OFFSET_W-1:0] offset,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rlga_pkg::yuv_beat_t               out_beat
);
    import rlga_pkg::*;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_ready;
    logic [FPROD_W-1:0] prod_reg [9];
    logic [FPROD_W-1:0] prod_next [9];

    logic               s2_valid_reg;
    logic               s2_valid_next;
    logic               s2_ready;
    yuv_beat_t          beat_reg;
    yuv_beat_t          beat_next;

    logic signed [YUV_W-1:0] y_sum;
    logic signed [YUV_W-1:0] offset_fix;

    // A stage takes a new beat when it is empty or its beat moves on.
    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
        prod_next[0] = FPROD_W'(FC_Y_R * red);
        prod_next[1] = FPROD_W'(FC_Y_G * green);
        prod_next[2] = FPROD_W'(FC_Y_B * blue);
        prod_next[3] = FPROD_W'(FC_U_R * red);
        prod_next[4] = FPROD_W'(FC_U_G * green);
        prod_next[5] = FPROD_W'(FC_U_B * blue);
        prod_next[6] = FPROD_W'(FC_V_R * red);
        prod_next[7] = FPROD_W'(FC_V_G * green);
        prod_next[8] = FPROD_W'(FC_V_B * blue);
    end

    always_comb
    begin
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
        y_sum = $signed(YUV_W'(prod_reg[0]) + YUV_W'(prod_reg[1]) + YUV_W'(prod_reg[2]));
        offset_fix = $signed({{(YUV_W-OFFSET_W){offset[OFFSET_W-1]}}, offset})
                     <<< (COEF_FRAC_BITS - OFFSET_FRAC_BITS);
        beat_next.gray = clamp_yuv(y_sum);
        beat_next.luma = y_sum + offset_fix;
        beat_next.chroma_u = $signed(YUV_W'(prod_reg[5]) - YUV_W'(prod_reg[3])
                                     - YUV_W'(prod_reg[4]));
        beat_next.chroma_v = $signed(YUV_W'(prod_reg[6]) - YUV_W'(prod_reg[7])
                                     - YUV_W'(prod_reg[8]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            prod_reg <= prod_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_beat = beat_reg;

endmodule

FILE: design/rlga_inv.sv
// Inverse conversion: chroma products in the third stage, RGB sums, clamp and mode select in the fourth.
module rlga_inv (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rlga_pkg::yuv_beat_t in_beat,
    input  logic                mode,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          red,
    output logic [7:0]          green,
    output logic [7:0]          blue
);
    import rlga_pkg::*;

    logic                    s3_valid_reg;
    logic                    s3_valid_next;
    logic                    s3_ready;
    logic [7:0]              gray_reg;
    logic signed [YUV_W-1:0] luma_reg;
    logic signed [SUM_W-1:0] rv_reg;
    logic signed [SUM_W-1:0] gu_reg;
    logic signed [SUM_W-1:0] gv_reg;
    logic signed [SUM_W-1:0] bu_reg;
    logic signed [SUM_W-1:0] rv_next;
    logic signed [SUM_W-1:0] gu_next;
    logic signed [SUM_W-1:0] gv_next;
    logic signed [SUM_W-1:0] bu_next;

    logic                    s4_valid_reg;
    logic                    s4_valid_next;
    logic                    s4_ready;
    logic [7:0]              red_reg;
    logic [7:0]              green_reg;
    logic [7:0]              blue_reg;
    logic [7:0]              red_next;
    logic [7:0]              green_next;
    logic [7:0]              blue_next;

    logic signed [SUM_W-1:0] luma_ext;
    logic signed [SUM_W-1:0] luma_fix;

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign in_ready = s3_ready;

    always_comb
    begin
        s3_valid_next = s3_ready ? in_valid : s3_valid_reg;
        rv_next = IC_R_V * in_beat.chroma_v;
        gu_next = IC_G_U * in_beat.chroma_u;
        gv_next = IC_G_V * in_beat.chroma_v;
        bu_next = IC_B_U * in_beat.chroma_u;
    end

    always_comb
    begin
        s4_valid_next = s4_ready ? s3_valid_reg : s4_valid_reg;
        luma_ext = {{(SUM_W-YUV_W){luma_reg[YUV_W-1]}}, luma_reg};
        luma_fix = luma_ext <<< COEF_FRAC_BITS;
        if (mode == MODE_ADJUST)
        begin
            red_next = clamp_sum(luma_fix + rv_reg);
            green_next = clamp_sum(luma_fix - gu_reg - gv_reg);
            blue_next = clamp_sum(luma_fix + bu_reg);
        end
        else
        begin
            red_next = gray_reg;
            green_next = gray_reg;
            blue_next = gray_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && in_valid)
        begin
            gray_reg <= in_beat.gray;
            luma_reg <= in_beat.luma;
            rv_reg <= rv_next;
            gu_reg <= gu_next;
            gv_reg <= gv_next;
            bu_reg <= bu_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            red_reg <= red_next;
            green_reg <= green_next;
            blue_reg <= blue_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign red = red_reg;
    assign green = green_reg;
    assign blue = blue_reg;

endmodule

FILE: design/rgb_luma_gray_or_adjust.sv
// Top level of the RGB luma converter: configuration registers, pipeline and checks.
//
// Takes one RGB pixel per beat and returns one RGB pixel per beat. The pixel is
// converted to Y, U and V with BT.601-style fixed-point coefficients. With mode_select
// at 0 all three outputs carry the luma, clamped to 0..255 and truncated. With
// mode_select at 1 the signed luma_offset (in sixteenths) is added to Y, the pixel is
// converted back to RGB, and each channel is clamped to 0..255 and truncated. The
// block is a four-stage pipeline: forward products, Y/U/V sums, inverse products, and
// RGB sums with clamping into the output register. A new pixel is taken every cycle
// while pixel_stall is low. A pixel accepted at a clock edge passes through the
// product, sum, inverse-product and output registers in that order before its
// result is valid on the result channel. Every stage has its own valid bit, so empty
// stages fill up while the output is stalled; pixel_stall rises only when all four
// stages hold a beat and result_stall is high. Configuration writes take effect on
// the next clock edge and should be made only while no pixel is in flight.
module rgb_luma_gray_or_adjust (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [rlga_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    input  logic [7:0]                        red_in,
    input  logic [7:0]                        green_in,
    input  logic [7:0]                        blue_in,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [7:0]                        red_out,
    output logic [7:0]                        green_out,
    output logic [7:0]                        blue_out
);
    import rlga_pkg::*;

    logic                       mode_reg;
    logic                       mode_next;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic signed [OFFSET_W-1:0] offset_next;

    logic                       fwd_ready;
    logic                       yuv_valid;
    logic                       yuv_ready;
    yuv_beat_t                  yuv_beat;

    // Register writes; an index with no register behind it is ignored.
    always_comb
    begin
        mode_next = mode_reg;
        offset_next = offset_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE_SELECT: mode_next = cfg_data[0];
                REG_LUMA_OFFSET: offset_next = $signed(cfg_data[OFFSET_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_GRAY;
            offset_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            offset_reg <= offset_next;
        end
    end

    rlga_fwd u_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel_valid),
        .in_ready  (fwd_ready),
        .red       (red_in),
        .green     (green_in),
        .blue      (blue_in),
        .offset    (offset_reg),
        .out_valid (yuv_valid),
        .out_ready (yuv_ready),
        .out_beat  (yuv_beat)
    );

    rlga_inv u_inv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (yuv_valid),
        .in_ready  (yuv_ready),
        .in_beat   (yuv_beat),
        .mode      (mode_reg),
        .out_valid (result_valid),
        .out_ready (!result_stall),
        .red       (red_out),
        .green     (green_out),
        .blue      (blue_out)
    );

    assign pixel_stall = !fwd_ready;

`ifndef SYNTHESIS
    // The input side can only be held off when the whole pipeline is full and blocked.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (result_valid && result_stall && yuv_valid))
        else $error("pixel_stall raised while the pipeline has room");

    a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == REG_MODE_SELECT) |=> (mode_reg == $past(cfg_data[0])))
        else $error("mode_select write not taken");

    a_offset_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == REG_LUMA_OFFSET)
        |=> (offset_reg == $signed($past(cfg_data[OFFSET_W-1:0]))))
        else $error("luma_offset write not taken");
`endif

endmodule
